[src/round_robin_time_slice_scheduler_assert.svh]
// Assertion macros for the round-robin scheduler.
// Depends on nothing; included by the top level.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH
// check that a condition implies a consequence in the same cycle
`define RR_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// check that a condition implies a consequence in the next cycle
`define RR_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[src/rrts_pkg.sv]
// Package for the round-robin scheduler: payload words and slice codes.
// Depends on nothing.
`default_nettype none
package rrts_pkg;
    localparam logic [1:0] KIND_IDLE = 2'd0;
    localparam logic [1:0] KIND_RAN  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic       FUNC_LOAD = 1'b0;
    localparam logic       FUNC_STEP = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  slice_kind;
        logic [4:0]  process_id;
        logic [23:0] slice_start;
        logic [23:0] slice_end;
        logic        process_finished;
        logic [23:0] completion_time;
        logic [23:0] turnaround_time;
        logic [23:0] waiting_time;
    } out_word_t;
endpackage
`default_nettype wire

[src/round_robin_time_slice_scheduler.sv]
// Round-robin time-slice scheduler, top level.
// Depends on rrts_pkg and round_robin_time_slice_scheduler_assert.svh.
//
// A word is taken when start is high and busy is low; busy stays high until
// the word is done. A load walks the table one entry per cycle to find its
// place and shifts later entries down one per cycle; the walk and the shift
// together cover the loaded entries once.
// A step admits arrived processes one per cycle through the single compare
// unit, runs the head (or, with an empty queue, an idle slice), admits again
// and requeues; all admissions of one step together cover the table at most once.
// The result shows for one cycle with result_valid, in the first cycle after
// busy falls; the receiver cannot stall it. cfg_ready is low while busy.
// Tables are flip-flop arrays.
`default_nettype none
`include "round_robin_time_slice_scheduler_assert.svh"
module round_robin_time_slice_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire rrts_pkg::in_word_t cmd,
    output logic                   result_valid,
    output rrts_pkg::out_word_t    result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [15:0]       cfg_data
);
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_SHIFT, S_PUT, S_ADMIT1, S_POP, S_RUN,
        S_ADMIT2, S_FINISH, S_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] quantum_reg;
    logic [15:0] arr_mem [MAX_PROCS];
    logic [15:0] bur_mem [MAX_PROCS];
    logic [15:0] rem_mem [MAX_PROCS];
    logic [4:0]  id_mem  [MAX_PROCS];
    logic [IW-1:0] fifo_mem [MAX_PROCS];
    logic [IW-1:0] head_reg, slot_reg;
    logic [CW-1:0] fcount_reg, loaded_reg, admit_reg, done_reg, pos_reg, k_reg;
    logic [23:0] time_reg, start_reg;
    logic [15:0] run_reg;
    logic started_reg;
    logic [15:0] a_reg, b_reg;
    rrts_pkg::out_word_t res_reg;
    logic valid_reg;

    // shared compare: table entry at the walked index against a key
    logic [CW-1:0] walk_idx;
    logic [15:0] walk_arr;
    logic [23:0] walk_key;
    logic walk_le;
    logic [15:0] q_eff;
    logic [IW-1:0] tail_idx;
    logic [CW:0] tail_sum;
    always_comb
    begin
        walk_idx = (state_reg == S_FIND) ? pos_reg : admit_reg;
        walk_arr = arr_mem[walk_idx[IW-1:0]];
        walk_key = (state_reg == S_FIND) ? {8'd0, a_reg} : time_reg;
        walk_le  = {8'd0, walk_arr} <= walk_key;
        q_eff    = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
        tail_sum = {{(CW+1-IW){1'b0}}, head_reg} + {1'b0, fcount_reg};
        tail_idx = (tail_sum >= (CW+1)'(MAX_PROCS))
            ? IW'(tail_sum - (CW+1)'(MAX_PROCS)) : IW'(tail_sum);
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign result_valid = valid_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            quantum_reg <= 16'd4;
            head_reg <= '0;
            fcount_reg <= '0;
            loaded_reg <= '0;
            admit_reg <= '0;
            done_reg <= '0;
            time_reg <= '0;
            started_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                quantum_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        a_reg <= cmd.arrival_time;
                        b_reg <= cmd.burst_time;
                        pos_reg <= '0;
                        k_reg <= loaded_reg;
                        if (cmd.func == rrts_pkg::FUNC_LOAD)
                        begin
                            if (!started_reg && loaded_reg < CW'(MAX_PROCS))
                                state_reg <= S_FIND;
                        end
                        else
                        begin
                            started_reg <= 1'b1;
                            if (done_reg >= loaded_reg)
                            begin
                                res_reg <= {rrts_pkg::KIND_DONE, 5'd0, time_reg, time_reg,
                                            1'b0, 72'd0};
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                res_reg <= '0;
                                state_reg <= S_ADMIT1;
                            end
                        end
                    end
                S_FIND:
                    if (pos_reg < loaded_reg && walk_le)
                        pos_reg <= pos_reg + 1'b1;
                    else
                        state_reg <= S_SHIFT;
                S_SHIFT:
                    if (k_reg > pos_reg)
                    begin
                        arr_mem[k_reg[IW-1:0]] <= arr_mem[IW'(k_reg - 1'b1)];
                        bur_mem[k_reg[IW-1:0]] <= bur_mem[IW'(k_reg - 1'b1)];
                        rem_mem[k_reg[IW-1:0]] <= rem_mem[IW'(k_reg - 1'b1)];
                        id_mem[k_reg[IW-1:0]]  <= id_mem[IW'(k_reg - 1'b1)];
                        k_reg <= k_reg - 1'b1;
                    end
                    else
                        state_reg <= S_PUT;
                S_PUT:
                begin
                    arr_mem[pos_reg[IW-1:0]] <= a_reg;
                    bur_mem[pos_reg[IW-1:0]] <= b_reg;
                    rem_mem[pos_reg[IW-1:0]] <= b_reg;
                    id_mem[pos_reg[IW-1:0]] <= 5'(loaded_reg + 1'b1);
                    loaded_reg <= loaded_reg + 1'b1;
                    state_reg <= S_IDLE;
                end
                S_ADMIT1, S_ADMIT2:
                    if (admit_reg < loaded_reg && walk_le)
                    begin
                        if (fcount_reg < CW'(MAX_PROCS))
                        begin
                            fifo_mem[tail_idx] <= admit_reg[IW-1:0];
                            fcount_reg <= fcount_reg + 1'b1;
                        end
                        admit_reg <= admit_reg + 1'b1;
                    end
                    else
                        state_reg <= (state_reg == S_ADMIT1) ? S_POP : S_FINISH;
                S_POP:
                    if (fcount_reg == '0)
                    begin
                        res_reg.slice_kind <= rrts_pkg::KIND_IDLE;
                        res_reg.slice_start <= time_reg;
                        res_reg.slice_end <= time_reg + 24'd1;
                        time_reg <= time_reg + 24'd1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        slot_reg <= fifo_mem[head_reg];
                        head_reg <= (CW'(head_reg) == CW'(MAX_PROCS - 1))
                            ? '0 : head_reg + 1'b1;
                        fcount_reg <= fcount_reg - 1'b1;
                        run_reg <= (rem_mem[fifo_mem[head_reg]] < q_eff)
                            ? rem_mem[fifo_mem[head_reg]] : q_eff;
                        state_reg <= S_RUN;
                    end
                S_RUN:
                begin
                    start_reg <= time_reg;
                    time_reg <= time_reg + {8'd0, run_reg};
                    rem_mem[slot_reg] <= rem_mem[slot_reg] - run_reg;
                    state_reg <= S_ADMIT2;
                end
                S_FINISH:
                begin
                    res_reg.slice_kind <= rrts_pkg::KIND_RAN;
                    res_reg.process_id <= id_mem[slot_reg];
                    res_reg.slice_start <= start_reg;
                    res_reg.slice_end <= time_reg;
                    if (rem_mem[slot_reg] != 16'd0)
                    begin
                        if (fcount_reg < CW'(MAX_PROCS))
                        begin
                            fifo_mem[tail_idx] <= slot_reg;
                            fcount_reg <= fcount_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        res_reg.process_finished <= 1'b1;
                        res_reg.completion_time <= time_reg;
                        res_reg.turnaround_time <= time_reg - {8'd0, arr_mem[slot_reg]};
                        res_reg.waiting_time <= time_reg - {8'd0, arr_mem[slot_reg]}
                            - {8'd0, bur_mem[slot_reg]};
                        done_reg <= done_reg + 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `RR_ASSERT_IMP(a_valid_idle, clk, rst_n, valid_reg, state_reg == S_IDLE)
    `RR_ASSERT_IMP(a_fifo_bound, clk, rst_n, 1'b1, fcount_reg <= loaded_reg)
    `RR_ASSERT_IMP(a_done_bound, clk, rst_n, 1'b1, done_reg <= loaded_reg)
    `RR_ASSERT_NEXT(a_out_valid, clk, rst_n, state_reg == S_OUT, valid_reg)
endmodule
`default_nettype wire
